FILE: sv/tcwq_pkg.sv
// tcwq_pkg: shared types, codes and sizes for the two-class weighted queue
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tcwq_pkg;

  // queue geometry
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);
  localparam int unsigned DataW      = 32;

  // burst limit register
  localparam int unsigned LimitW     = 4;
  localparam logic [LimitW-1:0] LimitReset = 4'd4;
  localparam logic [LimitW-1:0] RunMax     = 4'd15;

  // configuration port
  localparam int unsigned AddrW      = 3;
  localparam logic [AddrW-1:0] RegLimitAddr = 3'd0;

  // operation codes
  localparam logic OpEnqueue = 1'b0;
  localparam logic OpServe   = 1'b1;

  // class codes
  localparam logic ClassPref   = 1'b0;
  localparam logic ClassNormal = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SERVED   = 2'd2,
    ST_NOTHING  = 2'd3
  } status_e;

  // per-queue occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // decisions for one accepted beat
  typedef struct packed {
    logic    push_norm;
    logic    push_pref;
    logic    pop_norm;
    logic    pop_pref;
    status_e status;
    logic    served_class;
  } arb_ctl_t;

endpackage

`default_nettype wire

FILE: sv/two_class_weighted_queue.sv
// two_class_weighted_queue: top level, two class queues with a weighted server
// depends on tcwq_pkg, tcwq_fifo, tcwq_arb, tcwq_apb
//
// Usage:
//   A command beat (operation_i, item_value_i, item_class_i) is taken at a
//   rising edge where start is high and busy is low. busy stays low, so one
//   beat can be taken on every cycle.
//   Enqueue appends item_value_i to the normal or preferential queue, each
//   QueueDepth entries; a full queue drops the beat and reports it.
//   Serve pops preferential entries until the run count exceeds the burst
//   limit, then forces one normal entry; an empty side yields to the other.
//   Each beat gives exactly one result on status_o, served_value_o and
//   served_class_o, marked by result_valid_o for one cycle, in the cycle after
//   the beat is taken. Throughput is one beat per cycle, set by the single
//   pointer/count update and the registered memory read per queue.
//   The receiver cannot stall; results are not held.
//   Reset empties both queues, clears the run count and sets the burst
//   limit to 4. Queue memories are not cleared; no clearing pass runs.
//   The burst limit sits at byte address 0 of the apb-style port.
`timescale 1ns / 1ps
`default_nettype none

module two_class_weighted_queue
  import tcwq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              operation_i,
  input  wire logic [DataW-1:0]  item_value_i,
  input  wire logic              item_class_i,
  // result channel
  output logic                   result_valid_o,
  output logic      [1:0]        status_o,
  output logic      [DataW-1:0]  served_value_o,
  output logic                   served_class_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic              accept;
  logic [LimitW-1:0] limit;
  fifo_stat_t        norm_stat, pref_stat;
  arb_ctl_t          ctl;
  logic [DataW-1:0]  norm_rdata, pref_rdata;
  logic              valid_q;
  status_e           status_q;
  logic              class_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration
  tcwq_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // decision logic
  tcwq_arb u_arb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .item_class_i (item_class_i),
    .norm_stat_i  (norm_stat),
    .pref_stat_i  (pref_stat),
    .limit_i      (limit),
    .ctl_o        (ctl)
  );

  // normal queue
  tcwq_fifo u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ctl.push_norm),
    .pop_i   (ctl.pop_norm),
    .wdata_i (item_value_i),
    .stat_o  (norm_stat),
    .rdata_o (norm_rdata)
  );

  // preferential queue
  tcwq_fifo u_pref (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ctl.push_pref),
    .pop_i   (ctl.pop_pref),
    .wdata_i (item_value_i),
    .stat_o  (pref_stat),
    .rdata_o (pref_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= ctl.status;
      class_q  <= (ctl.status == ST_SERVED) ? ctl.served_class : 1'b0;
    end
  end

  // result beat
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign served_class_o = class_q;
  assign served_value_o = (status_q != ST_SERVED)  ? '0 :
                          (class_q == ClassNormal) ? norm_rdata : pref_rdata;

  // one result beat in the cycle after each accepted command
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("result beat missing after accepted command");

  // at most one queue is touched per beat
  a_one_queue_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.push_norm, ctl.push_pref, ctl.pop_norm, ctl.pop_pref}))
    else $error("more than one queue operation in one beat");

  // a normal class result only comes with a served status
  a_class_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && served_class_o) |-> (status_o == ST_SERVED))
    else $error("served class set without a served status");

  // nothing to serve only when both queues were empty at the command
  a_nothing_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OpServe && !(norm_stat.empty && pref_stat.empty))
      |=> (status_o == ST_SERVED))
    else $error("serve reported empty with entries queued");

endmodule

`default_nettype wire

FILE: sv/tcwq_fifo.sv
// tcwq_fifo: one class queue, a memory with read/write pointers and a fill count
// depends on tcwq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcwq_fifo
  import tcwq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic             pop_i,
  input  wire logic [DataW-1:0] wdata_i,
  output fifo_stat_t            stat_o,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [QueueDepth];
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [DataW-1:0] rdata_q;

  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(QueueDepth);

  // occupancy flags
  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (fill_q == FillFull);

  // pointer and fill update, callers only push when not full and pop when not empty
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      fill_d   = fill_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      fill_d   = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  // registered head read on pop
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/tcwq_arb.sv
// tcwq_arb: per-beat decision logic and preferential run counter
// depends on tcwq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcwq_arb
  import tcwq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              operation_i,
  input  wire logic              item_class_i,
  input  wire fifo_stat_t        norm_stat_i,
  input  wire fifo_stat_t        pref_stat_i,
  input  wire logic [LimitW-1:0] limit_i,
  output arb_ctl_t               ctl_o
);

  logic [LimitW-1:0] run_q, run_d;
  logic              take_norm;

  // normal wins when preferential is empty, or when normal is not empty and the run is over the limit
  assign take_norm = pref_stat_i.empty ||
                     (!norm_stat_i.empty && (run_q > limit_i));

  always_comb begin
    ctl_o              = '0;
    ctl_o.status       = ST_ENQUEUED;
    ctl_o.served_class = ClassPref;
    run_d              = run_q;
    if (operation_i == OpEnqueue) begin
      if (item_class_i == ClassNormal) begin
        if (norm_stat_i.full) begin
          ctl_o.status = ST_DROPPED;
        end else begin
          ctl_o.push_norm = accept_i;
        end
      end else begin
        if (pref_stat_i.full) begin
          ctl_o.status = ST_DROPPED;
        end else begin
          ctl_o.push_pref = accept_i;
        end
      end
    end else if (norm_stat_i.empty && pref_stat_i.empty) begin
      ctl_o.status = ST_NOTHING;
    end else begin
      ctl_o.status = ST_SERVED;
      if (take_norm) begin
        ctl_o.pop_norm     = accept_i;
        ctl_o.served_class = ClassNormal;
        run_d              = '0;
      end else begin
        ctl_o.pop_pref     = accept_i;
        ctl_o.served_class = ClassPref;
        run_d              = (run_q < RunMax) ? run_q + 1'b1 : run_q;
      end
    end
  end

  // run count moves only on accepted serve beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (accept_i) begin
      run_q <= run_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tcwq_apb.sv
// tcwq_apb: configuration register file behind the apb-style port
// depends on tcwq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcwq_apb
  import tcwq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [LimitW-1:0] limit_o
);

  logic [LimitW-1:0] limit_q;
  logic              wr_en;
  logic              sel_limit;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[AddrW-1:2] == RegLimitAddr[AddrW-1:2]);
  assign wr_en     = psel && penable && pwrite && pready && sel_limit;

  // burst limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (wr_en) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // read back
  assign prdata  = sel_limit ? {{(32-LimitW){1'b0}}, limit_q} : '0;
  assign limit_o = limit_q;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for two_class_weighted_queue
// holds a cycle-free predictor of both class queues and the weighted server
// depends on tcwq_pkg and the two_class_weighted_queue rtl
`timescale 1ns / 1ps

module testbench;
  import tcwq_pkg::*;

  // one predicted result beat
  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] value;
    logic             cls;
  } queue_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             operation_i;
  logic [DataW-1:0] item_value_i;
  logic             item_class_i;
  logic             result_valid_o;
  logic [1:0]       status_o;
  logic [DataW-1:0] served_value_o;
  logic             served_class_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  two_class_weighted_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .item_class_i   (item_class_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .served_value_o (served_value_o),
    .served_class_o (served_class_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // predictor state: both queues, run count and burst limit
  logic [DataW-1:0]  norm_mem [QueueDepth];
  logic [DataW-1:0]  pref_mem [QueueDepth];
  logic [PtrW-1:0]   norm_rd;
  logic [FillW-1:0]  norm_cnt;
  logic [PtrW-1:0]   pref_rd;
  logic [FillW-1:0]  pref_cnt;
  logic [LimitW-1:0] run_cnt;
  logic [LimitW-1:0] burst_limit;

  queue_result_t predicted_results [$];
  int unsigned   err_count;
  bit            idle_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // apply one accepted beat to the queues and return its result
  function automatic queue_result_t predict_queue_op(logic op, logic [DataW-1:0] val,
                                                     logic cls);
    queue_result_t r;
    logic          take_norm;
    r = '0;
    r.status = ST_ENQUEUED;
    if (op == OpEnqueue) begin
      if (cls == ClassNormal) begin
        if (norm_cnt == QueueDepth) begin
          r.status = ST_DROPPED;
        end else begin
          norm_mem[(norm_rd + norm_cnt) % QueueDepth] = val;
          norm_cnt = norm_cnt + 1'b1;
        end
      end else begin
        if (pref_cnt == QueueDepth) begin
          r.status = ST_DROPPED;
        end else begin
          pref_mem[(pref_rd + pref_cnt) % QueueDepth] = val;
          pref_cnt = pref_cnt + 1'b1;
        end
      end
    end else if (norm_cnt == 0 && pref_cnt == 0) begin
      r.status = ST_NOTHING;
    end else begin
      // an empty side yields, else the run count decides
      if (pref_cnt == 0) begin
        take_norm = 1'b1;
      end else if (norm_cnt == 0) begin
        take_norm = 1'b0;
      end else begin
        take_norm = run_cnt > burst_limit;
      end
      r.status = ST_SERVED;
      if (take_norm) begin
        r.value  = norm_mem[norm_rd];
        r.cls    = ClassNormal;
        norm_rd  = PtrW'((norm_rd + 1) % QueueDepth);
        norm_cnt = norm_cnt - 1'b1;
        run_cnt  = '0;
      end else begin
        r.value  = pref_mem[pref_rd];
        r.cls    = ClassPref;
        pref_rd  = PtrW'((pref_rd + 1) % QueueDepth);
        pref_cnt = pref_cnt - 1'b1;
        if (run_cnt != RunMax) begin
          run_cnt = run_cnt + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // predict on each accepted beat, then check each result beat
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        predicted_results.push_back(predict_queue_op(operation_i, item_value_i,
                                                     item_class_i));
      end
      if (result_valid_o) begin
        if (predicted_results.size() == 0) begin
          flag_error($sformatf("result with none outstanding: status %0d value %h",
                               status_o, served_value_o));
        end else begin
          want = predicted_results.pop_front();
          if (status_o !== want.status) begin
            flag_error($sformatf("status exp %0d got %0d", want.status, status_o));
          end
          if (served_value_o !== want.value) begin
            flag_error($sformatf("served_value exp %h got %h", want.value,
                                 served_value_o));
          end
          if (served_class_o !== want.cls) begin
            flag_error($sformatf("served_class exp %0d got %0d", want.cls,
                                 served_class_o));
          end
        end
      end
    end
  end

  // values biased toward the extremes
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // send one command beat, with a random gap before it when idling is on
  task automatic send_item(input logic op, input logic [DataW-1:0] val, input logic cls);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start        = 1'b1;
    operation_i  = op;
    item_value_i = val;
    item_class_i = cls;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    hold_off();
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_burst_limit(input logic [LimitW-1:0] lim);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = RegLimitAddr;
    pwdata  = {$urandom} & ~32'hf | 32'(lim);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    burst_limit = lim;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_burst_limit();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = RegLimitAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(burst_limit)) begin
      flag_error($sformatf("burst limit read exp %h got %h", 32'(burst_limit), prdata));
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // extremes of the value field, both classes, empty serve, forced normal,
  // empty preferential side and empty normal side
  task automatic test_directed();
    idle_on = 1'b0;
    check_burst_limit();
    send_item(OpServe, 32'h1234_5678, ClassNormal);
    send_item(OpEnqueue, 32'h8000_0000, ClassPref);
    send_item(OpEnqueue, 32'h7fff_ffff, ClassPref);
    send_item(OpEnqueue, 32'h0000_0000, ClassNormal);
    send_item(OpEnqueue, 32'hffff_ffff, ClassNormal);
    send_item(OpEnqueue, 32'h0000_0001, ClassPref);
    send_item(OpEnqueue, 32'h0000_0002, ClassPref);
    send_item(OpEnqueue, 32'h0000_0003, ClassPref);
    send_item(OpEnqueue, 32'h0000_0004, ClassPref);
    repeat (9) send_item(OpServe, 32'hffff_ffff, ClassPref);
    send_item(OpEnqueue, 32'h5555_aaaa, ClassPref);
    send_item(OpEnqueue, 32'haaaa_5555, ClassPref);
    repeat (3) send_item(OpServe, 32'h0, ClassNormal);
    drain();
  endtask

  // run count saturates at its maximum instead of wrapping
  task automatic test_run_saturation();
    idle_on = 1'b1;
    write_burst_limit(RunMax);
    check_burst_limit();
    repeat (20) send_item(OpEnqueue, pick_value(), ClassPref);
    repeat (2) send_item(OpEnqueue, pick_value(), ClassNormal);
    repeat (18) send_item(OpServe, $urandom, 1'($urandom));
    drain();
    write_burst_limit(RunMax - 1'b1);
    send_item(OpServe, $urandom, 1'($urandom));
    drain();
    write_burst_limit('0);
    repeat (5) send_item(OpServe, $urandom, 1'($urandom));
    drain();
  endtask

  // fill each queue past full, then empty it again
  task automatic test_queue_full();
    idle_on = 1'b1;
    write_burst_limit(LimitW'($urandom));
    for (int c = 0; c < 2; c++) begin
      repeat (QueueDepth + 3) send_item(OpEnqueue, pick_value(), 1'(c));
      repeat (QueueDepth + 2) send_item(OpServe, $urandom, 1'($urandom));
    end
    drain();
  endtask

  // random phases with different mixes, limits and idling
  task automatic test_random_mix();
    int unsigned enq_pct;
    int unsigned norm_pct;
    logic        op;
    for (int ph = 0; ph < 20; ph++) begin
      drain();
      if (ph == 0) begin
        write_burst_limit('0);
      end else if (ph == 1) begin
        write_burst_limit(RunMax);
      end else begin
        write_burst_limit(LimitW'($urandom));
      end
      if (ph % 5 == 4) begin
        check_burst_limit();
      end
      idle_on  = (ph % 3) != 0;
      enq_pct  = $urandom_range(20, 90);
      norm_pct = $urandom_range(10, 90);
      for (int i = 0; i < 100; i++) begin
        // mid-run pause until every result is back
        if (ph == 10 && i == 50) begin
          drain();
        end
        op = ($urandom_range(0, 99) < enq_pct) ? OpEnqueue : OpServe;
        send_item(op, pick_value(),
                  ($urandom_range(0, 99) < norm_pct) ? ClassNormal : ClassPref);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = OpEnqueue;
    item_value_i = '0;
    item_class_i = ClassPref;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    norm_rd      = '0;
    norm_cnt     = '0;
    pref_rd      = '0;
    pref_cnt     = '0;
    run_cnt      = '0;
    burst_limit  = LimitReset;
    err_count    = 0;
    idle_on      = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_run_saturation();
    test_queue_full();
    test_random_mix();

    drain();
    repeat (4) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", predicted_results.size()));
    end
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
